@@ rtl/cpts_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, datapath operation codes and status type for the circle point generator.
package cpts_pkg;

	// Field and register widths.
	localparam int TC_W      = 6;
	localparam int CFG_W     = 24;
	localparam int ANG_W     = 9;
	localparam int OUT_W     = 27;
	localparam int REG_IDX_W = 2;

	localparam int MAX_TERMS_DEF = 32;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_TERM_COUNT   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CIRCLE_RADIUS = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_X     = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_Y     = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [TC_W-1:0]  TERM_COUNT_RST = 6'd16;
	localparam logic [CFG_W-1:0] RADIUS_RST     = 24'd65536;
	localparam logic [CFG_W-1:0] CENTER_RST     = 24'd0;

	// Angle conversion.
	localparam logic [29:0] PI_Q28        = 30'd843314857;
	localparam int          DEG_FULL_TURN = 360;
	localparam int          DEG_HALF_TURN = 180;
	localparam int          DEG_ROUND     = DEG_HALF_TURN / 2;

	// The rounded quotient (degree * PI_Q28 + 90) / 180 splits into degree * PI_DEG_QUO plus
	// the quotient of the small value degree * PI_DEG_REM + 90, taken by a reciprocal multiply.
	// DEG_RECIP exceeds 2^24/180 by 44/180, so the floor is exact for values below 2^24/44,
	// well above the largest one that occurs.
	localparam int PI_DEG_QUO = int'(PI_Q28) / DEG_HALF_TURN;
	localparam int PI_DEG_REM = int'(PI_Q28) % DEG_HALF_TURN;
	localparam int DEG_RCP_SH = 24;
	localparam int DEG_RECIP  = ((1 << DEG_RCP_SH) + DEG_HALF_TURN - 1) / DEG_HALF_TURN;

	// Number formats.
	localparam int XQ_W    = 31;   // Q3.28 angle magnitude
	localparam int Q_FRAC  = 30;   // series fraction bits
	localparam int X2_SH   = 26;   // Q3.28 squared down to Q30
	localparam int SER_W   = 41;   // signed Q10.30 series values
	localparam int COORD_W = 36;   // signed coordinate before saturation

	// Shared multiplier: the A operand is consumed in chunks, most significant first.
	localparam int MUL_CH  = 24;
	localparam int MUL_NCH = 2;
	localparam int MUL_A_W = MUL_CH * MUL_NCH;
	localparam int MUL_B_W = 36;

	// Shared divider: restoring, several quotient bits per cycle.
	localparam int DVD_W     = 48;
	localparam int DIV_BITS  = 8;
	localparam int DIV_NSTEP = DVD_W / DIV_BITS;
	localparam int STEP_W    = $clog2(DIV_NSTEP);

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_ANG_SPLIT,
		OP_DIV,
		OP_ANG_DONE,
		OP_SQ_DONE,
		OP_TERM_MUL,
		OP_TERM_DIV,
		OP_TERM_UPD,
		OP_SIN_INIT,
		OP_X_MUL,
		OP_X_DONE,
		OP_Y_DONE
	} dp_op_t;

	typedef struct packed {
		logic more;   // another series term is due
		logic odd;    // the sine series is running
	} dp_stat_t;

endpackage

@@ rtl/cpts_dp.sv @@
`timescale 1ns / 1ps
// Datapath: angle conversion, shared multiplier and divider, series registers and output stage.
module cpts_dp #(
	parameter int MAX_TERMS = cpts_pkg::MAX_TERMS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cpts_pkg::dp_op_t                    op,
	input  logic [cpts_pkg::ANG_W-1:0]          angle_deg,
	input  logic [cpts_pkg::TC_W-1:0]           term_count,
	input  logic signed [cpts_pkg::CFG_W-1:0]   circle_radius,
	input  logic signed [cpts_pkg::CFG_W-1:0]   center_x,
	input  logic signed [cpts_pkg::CFG_W-1:0]   center_y,
	output cpts_pkg::dp_stat_t                  stat,
	output logic signed [cpts_pkg::OUT_W-1:0]   x_coord,
	output logic signed [cpts_pkg::OUT_W-1:0]   y_coord,
	output logic                                clipped
);
	import cpts_pkg::*;

	localparam int DMAX   = 2 * (MAX_TERMS - 1) * (2 * MAX_TERMS - 1);
	localparam int DEN_W  = $clog2(DMAX + 1);
	localparam int CNT_W  = $clog2(MAX_TERMS + 1);
	localparam int CMP_W  = (CNT_W > TC_W) ? CNT_W : TC_W;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int SQ_W   = 2 * XQ_W;
	localparam int P30_W  = PROD_W - Q_FRAC;
	localparam int ANGV_W = $clog2((DEG_FULL_TURN - 1) * PI_DEG_REM + DEG_ROUND + 1);
	localparam int RCP_W  = $clog2(DEG_RECIP + 1);
	localparam int ANGP_W = ANGV_W + RCP_W;

	localparam logic [SER_W-1:0] SER_ONE   = SER_W'(1) << Q_FRAC;
	localparam logic [SER_W-1:0] SER_MAXV  = {1'b0, {(SER_W-1){1'b1}}};
	localparam logic [SER_W-1:0] SER_MINV  = {1'b1, {(SER_W-1){1'b0}}};
	localparam logic [DVD_W-1:0] Q_POS_LIM = (DVD_W'(1) << (SER_W-1)) - DVD_W'(1);
	localparam logic [DVD_W-1:0] Q_NEG_LIM = DVD_W'(1) << (SER_W-1);
	localparam logic [OUT_W-1:0] OUT_MAXV  = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] OUT_MINV  = {1'b1, {(OUT_W-1){1'b0}}};

	function automatic logic [SER_W-1:0] ser_mag(input logic [SER_W-1:0] v);
		return v[SER_W-1] ? (~v + 1'b1) : v;
	endfunction

	// Angle conversion registers.
	logic [ANG_W-1:0]   deg_q;
	logic [XQ_W-1:0]    ang_hi_q;
	logic [ANGV_W-1:0]  ang_v_q;

	// Multiplier and divider working registers.
	logic [MUL_A_W-1:0] a_q;
	logic [MUL_B_W-1:0] b_q;
	logic [PROD_W-1:0]  acc_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [DEN_W-1:0]   rem_q;
	logic [DEN_W-1:0]   dsr_q;

	// Series registers.
	logic [XQ_W-1:0]    xq_q;
	logic [MUL_B_W-1:0] x2_q;
	logic [SER_W-1:0]   term_q;
	logic [SER_W-1:0]   sum_q;
	logic [SER_W-1:0]   cos_q;
	logic [CNT_W-1:0]   i_q;
	logic               odd_q;

	logic [OUT_W-1:0]   x_q;
	logic [OUT_W-1:0]   y_q;
	logic               clip_q;

	// Combinational values.
	logic [ANG_W-1:0]          deg_mod;
	logic [ANGP_W-1:0]         ang_rp;
	logic [XQ_W-1:0]           xq_nx;
	logic [MUL_CH+MUL_B_W-1:0] pp;
	logic [PROD_W-1:0]         acc_nx;
	logic [DVD_W-1:0]          dv;
	logic [DEN_W-1:0]          rr;
	logic [DEN_W:0]            rx;
	logic [DVD_W-1:0]          dvd_nx;
	logic [DEN_W-1:0]          rem_nx;
	logic [SQ_W-1:0]           sq_rnd;
	logic [PROD_W-1:0]         p_rnd;
	logic [P30_W-1:0]          p30;
	logic [DEN_W-1:0]          i2_w;
	logic [DEN_W-1:0]          f_w;
	logic [DEN_W-1:0]          d_w;
	logic [SER_W-1:0]          term_mag;
	logic [SER_W-1:0]          t_nx;
	logic [SER_W:0]            s_ext;
	logic [SER_W-1:0]          sum_nx;
	logic [CFG_W-1:0]          r_mag;
	logic [SER_W-1:0]          f_sel;
	logic [CFG_W-1:0]          c_sel;
	logic                      co_neg;
	logic [COORD_W-1:0]        pc;
	logic [COORD_W-1:0]        co_v;
	logic                      co_clip;
	logic [OUT_W-1:0]          co_val;

	assign deg_mod = (angle_deg >= ANG_W'(DEG_FULL_TURN)) ?
		angle_deg - ANG_W'(DEG_FULL_TURN) : angle_deg;

	// Radians in Q3.28: the large part plus the reciprocal quotient of the small part.
	assign ang_rp = {{RCP_W{1'b0}}, ang_v_q} * ANGP_W'(DEG_RECIP);
	assign xq_nx  = ang_hi_q + XQ_W'(ang_rp[ANGP_W-1:DEG_RCP_SH]);

	// One multiplier pass: the top chunk of A against all of B.
	assign pp     = a_q[MUL_A_W-1 -: MUL_CH] * b_q;
	assign acc_nx = (acc_q << MUL_CH) + PROD_W'(pp);

	// Restoring division, DIV_BITS quotient bits shifted into the dividend register.
	always_comb begin
		rr = rem_q;
		dv = dvd_q;
		rx = '0;
		for (int k = 0; k < DIV_BITS; k++) begin
			rx = {rr, dv[DVD_W-1]};
			dv = {dv[DVD_W-2:0], 1'b0};
			if (rx >= {1'b0, dsr_q}) begin
				rx    = rx - {1'b0, dsr_q};
				dv[0] = 1'b1;
			end
			rr = rx[DEN_W-1:0];
		end
		dvd_nx = dv;
		rem_nx = rr;
	end

	// Rounded rescaling of the finished product.
	assign sq_rnd = acc_q[SQ_W-1:0] + (SQ_W'(1) << (X2_SH - 1));
	assign p_rnd  = acc_q + (PROD_W'(1) << (Q_FRAC - 1));
	assign p30    = p_rnd[PROD_W-1:Q_FRAC];

	// Term denominator 2i(2i-1) for cosine, 2i(2i+1) for sine.
	assign i2_w = DEN_W'({i_q, 1'b0});
	assign f_w  = odd_q ? (i2_w + DEN_W'(1)) : (i2_w - DEN_W'(1));
	assign d_w  = i2_w * f_w;

	assign term_mag = ser_mag(term_q);

	// Next term takes the opposite sign of the current one, saturated to the series range.
	always_comb begin
		if (term_q[SER_W-1]) begin
			t_nx = (dvd_q > Q_POS_LIM) ? SER_MAXV : dvd_q[SER_W-1:0];
		end else begin
			t_nx = (dvd_q > Q_NEG_LIM) ? SER_MINV : (~dvd_q[SER_W-1:0] + 1'b1);
		end
	end

	assign s_ext  = {sum_q[SER_W-1], sum_q} + {t_nx[SER_W-1], t_nx};
	assign sum_nx = (s_ext[SER_W] != s_ext[SER_W-1]) ?
		(s_ext[SER_W] ? SER_MINV : SER_MAXV) : s_ext[SER_W-1:0];

	// Output coordinate: signed radius product plus center, saturated.
	assign r_mag  = circle_radius[CFG_W-1] ? (~circle_radius + 1'b1) : circle_radius;
	assign f_sel  = (op == OP_Y_DONE) ? sum_q : cos_q;
	assign c_sel  = (op == OP_Y_DONE) ? center_y : center_x;
	assign co_neg = f_sel[SER_W-1] ^ circle_radius[CFG_W-1];
	assign pc     = COORD_W'(p30);
	assign co_v   = (co_neg ? (~pc + 1'b1) : pc) +
		{{(COORD_W-CFG_W){c_sel[CFG_W-1]}}, c_sel};
	assign co_clip = !((&co_v[COORD_W-1:OUT_W-1]) || (~|co_v[COORD_W-1:OUT_W-1]));
	assign co_val  = co_clip ? (co_v[COORD_W-1] ? OUT_MINV : OUT_MAXV) : co_v[OUT_W-1:0];

	assign stat.more = (CMP_W'(i_q) < CMP_W'(term_count)) &&
		(CMP_W'(i_q) < CMP_W'(MAX_TERMS));
	assign stat.odd  = odd_q;

	// Series index and phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q   <= '0;
			odd_q <= 1'b0;
		end else begin
			case (op)
				OP_SQ_DONE: begin
					i_q   <= CNT_W'(1);
					odd_q <= 1'b0;
				end
				OP_SIN_INIT: begin
					i_q   <= CNT_W'(1);
					odd_q <= 1'b1;
				end
				OP_TERM_UPD: begin
					i_q <= i_q + CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				deg_q <= deg_mod;
			end
			OP_MUL: begin
				acc_q <= acc_nx;
				a_q   <= a_q << MUL_CH;
			end
			OP_ANG_SPLIT: begin
				ang_hi_q <= XQ_W'(deg_q) * XQ_W'(PI_DEG_QUO);
				ang_v_q  <= ANGV_W'(deg_q) * ANGV_W'(PI_DEG_REM) + ANGV_W'(DEG_ROUND);
			end
			OP_DIV: begin
				dvd_q <= dvd_nx;
				rem_q <= rem_nx;
			end
			OP_ANG_DONE: begin
				xq_q  <= xq_nx;
				a_q   <= MUL_A_W'(xq_nx);
				b_q   <= MUL_B_W'(xq_nx);
				acc_q <= '0;
			end
			OP_SQ_DONE: begin
				x2_q   <= sq_rnd[X2_SH +: MUL_B_W];
				term_q <= SER_ONE;
				sum_q  <= SER_ONE;
			end
			OP_TERM_MUL: begin
				a_q   <= MUL_A_W'(term_mag);
				b_q   <= x2_q;
				acc_q <= '0;
			end
			OP_TERM_DIV: begin
				dvd_q <= DVD_W'(p30) + DVD_W'(d_w >> 1);
				rem_q <= '0;
				dsr_q <= d_w;
			end
			OP_TERM_UPD: begin
				term_q <= t_nx;
				sum_q  <= sum_nx;
			end
			OP_SIN_INIT: begin
				cos_q  <= sum_q;
				term_q <= SER_W'({xq_q, 2'b00});
				sum_q  <= SER_W'({xq_q, 2'b00});
			end
			OP_X_MUL: begin
				a_q   <= MUL_A_W'(ser_mag(cos_q));
				b_q   <= MUL_B_W'(r_mag);
				acc_q <= '0;
			end
			OP_X_DONE: begin
				x_q    <= co_val;
				clip_q <= co_clip;
				a_q    <= MUL_A_W'(ser_mag(sum_q));
				b_q    <= MUL_B_W'(r_mag);
				acc_q  <= '0;
			end
			OP_Y_DONE: begin
				y_q    <= co_val;
				clip_q <= clip_q | co_clip;
			end
			default: begin
			end
		endcase
	end

	assign x_coord = x_q;
	assign y_coord = y_q;
	assign clipped = clip_q;

endmodule

@@ rtl/cpts_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: sequences the datapath through angle conversion, both series and the output stage.
module cpts_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  cpts_pkg::dp_stat_t stat,
	output cpts_pkg::dp_op_t   op,
	output logic               busy,
	output logic               done
);
	import cpts_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ANG_SPLIT,
		ST_ANG_FIN,
		ST_SQ_MUL,
		ST_SQ_FIN,
		ST_TERM_CHK,
		ST_T_MUL,
		ST_T_DIVLD,
		ST_T_DIV,
		ST_T_UPD,
		ST_X_MUL,
		ST_X_FIN,
		ST_Y_MUL,
		ST_Y_FIN
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              done_q;
	logic              mul_last;
	logic              div_last;

	assign mul_last = (step_q == STEP_W'(MUL_NCH - 1));
	assign div_last = (step_q == STEP_W'(DIV_NSTEP - 1));
	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;

	always_comb begin
		unique case (state_q) inside
			ST_IDLE:                                    op = start ? OP_LOAD : OP_NONE;
			ST_SQ_MUL, ST_T_MUL, ST_X_MUL, ST_Y_MUL:    op = OP_MUL;
			ST_ANG_SPLIT:                               op = OP_ANG_SPLIT;
			ST_T_DIV:                                   op = OP_DIV;
			ST_ANG_FIN:                                 op = OP_ANG_DONE;
			ST_SQ_FIN:                                  op = OP_SQ_DONE;
			ST_TERM_CHK: begin
				if (stat.more) begin
					op = OP_TERM_MUL;
				end else if (stat.odd) begin
					op = OP_X_MUL;
				end else begin
					op = OP_SIN_INIT;
				end
			end
			ST_T_DIVLD:                                 op = OP_TERM_DIV;
			ST_T_UPD:                                   op = OP_TERM_UPD;
			ST_X_FIN:                                   op = OP_X_DONE;
			ST_Y_FIN:                                   op = OP_Y_DONE;
			default:                                    op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (start) begin
						state_q <= ST_ANG_SPLIT;
					end
				end
				ST_ANG_SPLIT: state_q <= ST_ANG_FIN;
				ST_ANG_FIN: state_q <= ST_SQ_MUL;
				ST_SQ_MUL: begin
					if (mul_last) begin
						step_q  <= '0;
						state_q <= ST_SQ_FIN;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_SQ_FIN: state_q <= ST_TERM_CHK;
				ST_TERM_CHK: begin
					// With no term left, the cosine phase hands over to the sine series
					// in place; the sine phase moves on to the output stage.
					if (stat.more) begin
						state_q <= ST_T_MUL;
					end else if (stat.odd) begin
						state_q <= ST_X_MUL;
					end
				end
				ST_T_MUL: begin
					if (mul_last) begin
						step_q  <= '0;
						state_q <= ST_T_DIVLD;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_T_DIVLD: state_q <= ST_T_DIV;
				ST_T_DIV: begin
					if (div_last) begin
						step_q  <= '0;
						state_q <= ST_T_UPD;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_T_UPD: state_q <= ST_TERM_CHK;
				ST_X_MUL: begin
					if (mul_last) begin
						step_q  <= '0;
						state_q <= ST_X_FIN;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_X_FIN: state_q <= ST_Y_MUL;
				ST_Y_MUL: begin
					if (mul_last) begin
						step_q  <= '0;
						state_q <= ST_Y_FIN;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_Y_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/circle_point_taylor_sincos.sv @@
`timescale 1ns / 1ps
// Top level: configuration registers, controller and datapath of the circle point generator.
//
// One point of a circle per beat: an angle in whole degrees (wrapped modulo 360) is turned
// into radians, cosine and sine are summed from Taylor series, and the point is
// radius*cos + center_x, radius*sin + center_y in signed Q10.16, saturated with a flag.
// An angle is taken when start is high and busy is low. The result is on x_coord, y_coord
// and clipped, marked by done high for a single cycle, and must be taken in that cycle; the
// next angle may be started in that same cycle. Each series sums term_count terms, capped
// at MAX_TERMS and at least one. A term takes two passes through the shared 24x36
// multiplier, the shared divider at eight quotient bits per cycle over the 48-bit dividend,
// and the control states ST_TERM_CHK, ST_T_DIVLD and ST_T_UPD. Turning the angle into
// radians runs ST_ANG_SPLIT and ST_ANG_FIN, squaring it two multiplier passes and ST_SQ_FIN,
// and the output stage two multiplier passes and a finishing state for each coordinate.
// Configuration is written through wr_en, wr_index and wr_data; the user must do so only
// while busy is low, which the block itself does not enforce.
module circle_point_taylor_sincos #(
	parameter int MAX_TERMS = cpts_pkg::MAX_TERMS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [cpts_pkg::ANG_W-1:0]          angle_deg,
	output logic                                busy,
	output logic                                done,
	output logic signed [cpts_pkg::OUT_W-1:0]   x_coord,
	output logic signed [cpts_pkg::OUT_W-1:0]   y_coord,
	output logic                                clipped,
	input  logic                                wr_en,
	input  logic [cpts_pkg::REG_IDX_W-1:0]      wr_index,
	input  logic [cpts_pkg::CFG_W-1:0]          wr_data
);
	import cpts_pkg::*;

	logic [TC_W-1:0]  term_count_q;
	logic [CFG_W-1:0] circle_radius_q;
	logic [CFG_W-1:0] center_x_q;
	logic [CFG_W-1:0] center_y_q;

	dp_op_t   op;
	dp_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q    <= TERM_COUNT_RST;
			circle_radius_q <= RADIUS_RST;
			center_x_q      <= CENTER_RST;
			center_y_q      <= CENTER_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TERM_COUNT:    term_count_q    <= wr_data[TC_W-1:0];
				REG_CIRCLE_RADIUS: circle_radius_q <= wr_data;
				REG_CENTER_X:      center_x_q      <= wr_data;
				REG_CENTER_Y:      center_y_q      <= wr_data;
				default: begin
				end
			endcase
		end
	end

	cpts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.op     (op),
		.busy   (busy),
		.done   (done)
	);

	cpts_dp #(
		.MAX_TERMS (MAX_TERMS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.angle_deg     (angle_deg),
		.term_count    (term_count_q),
		.circle_radius (circle_radius_q),
		.center_x      (center_x_q),
		.center_y      (center_y_q),
		.stat          (stat),
		.x_coord       (x_coord),
		.y_coord       (y_coord),
		.clipped       (clipped)
	);

endmodule
